// File: design/mbfr_pkg.sv
// Shared types, codes and constants for the monochrome bitmap flip/rotate core.
// Used by the controller, the datapath and the top level.
// No dependencies.
package mbfr_pkg;

  // Fixed field widths
  localparam int DIM_W    = 11;  // width/height registers
  localparam int ROW_W    = 10;
  localparam int COL_W    = 7;
  localparam int PIX_W    = 10;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int MODE_W   = 2;
  localparam int STRIDE_W = 9;   // ceil(2047 / 8) fits in 9 bits
  localparam int STEP_W   = 3;   // one step per pixel of a byte
  localparam int DIM_MAX  = 2047;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration register map
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [DIM_W-1:0]  RST_WIDTH  = 11'd600;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 11'd800;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_PIXEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ       = 2'd2;

  // Readout views
  localparam logic [MODE_W-1:0] MODE_AS_STORED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLIP_H    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLIP_V    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ROTATE    = 2'd3;

  localparam logic [MODE_W-1:0] RST_MODE = MODE_AS_STORED;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row_index;
    logic [COL_W-1:0]  byte_column;
    logic [BYTE_W-1:0] byte_data;
    logic [PIX_W-1:0]  pixel_x;
    logic [PIX_W-1:0]  pixel_y;
    logic              pixel_value;
  } item_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic is_read;
  } dp_sts_t;

  localparam logic [STEP_W-1:0] STEP_LAST  = 3'd7;
  localparam logic [STEP_W-1:0] DRAIN_LAST = 3'd1;

endpackage

// File: design/mbfr_ctrl.sv
// Sequencer for the bitmap core: input handshake, store access steps and
// the output register handshake. Depends on mbfr_pkg.
module mbfr_ctrl
  import mbfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (!sts_i.hit || !sts_i.is_read || cnt_q == STEP_LAST) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cnt_q == DRAIN_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ISSUE: begin
        cmd_o.issue = sts_i.hit;
        cmd_o.step  = cnt_q;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_DONE: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: cmd_o = '0;
    endcase
  end

  // Step / drain counter, cleared on every state change
  always_comb begin
    if (state_d != state_q) cnt_d = '0;
    else if (state_q == ST_ISSUE || state_q == ST_DRAIN) cnt_d = cnt_q + 3'd1;
    else cnt_d = '0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/mbfr_datapath.sv
// Datapath of the bitmap core: item and geometry registers, source address
// generation, the image store and bit gathering. Depends on mbfr_pkg.
module mbfr_datapath
  import mbfr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  item_t             item_i,
  input  logic [DIM_W-1:0]  width_i,
  input  logic [DIM_W-1:0]  height_i,
  input  logic [MODE_W-1:0] mode_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_hit_o
);

  localparam int StrideMax = (MAX_WIDTH + 7) / 8;
  localparam int Depth     = StrideMax * MAX_HEIGHT;
  localparam int AW        = $clog2(Depth);
  localparam int WClamp    = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
  localparam int HClamp    = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
  localparam int ProdW     = DIM_W + STRIDE_W;
  localparam int CalcW     = ProdW + 1;

  localparam logic [DIM_W-1:0] WMax = DIM_W'(WClamp);
  localparam logic [DIM_W-1:0] HMax = DIM_W'(HClamp);

  item_t               item_q;
  logic [DIM_W-1:0]    w_q, h_q;
  logic [STRIDE_W-1:0] stride_q, vstride_q;
  logic [MODE_W-1:0]   mode_q;

  logic [DIM_W-1:0]    w_d, h_d;
  logic [DIM_W:0]      w_sum, h_sum;

  logic                hit;
  logic [DIM_W-1:0]    row11, xk, sx, sy;
  logic                en;
  logic [ProdW-1:0]    prod;
  logic [CalcW-1:0]    addr_calc;

  logic                v1_q, v2_q;
  logic [AW-1:0]       addr1_q, addr2_q;
  logic [STEP_W-1:0]   sel1_q, sel2_q, k1_q, k2_q;
  logic                en1_q, en2_q;
  logic [BYTE_W-1:0]   rd_q;
  logic [BYTE_W-1:0]   result_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic                out_hit_q;

  logic                wr_en;
  logic [BYTE_W-1:0]   wr_data, pix_mask;

  logic [BYTE_W-1:0]   store_mem [Depth];

  // Clamp the geometry when the item is taken
  always_comb begin
    if (width_i == '0) w_d = DIM_W'(1);
    else if (width_i > WMax) w_d = WMax;
    else w_d = width_i;
    if (height_i == '0) h_d = DIM_W'(1);
    else if (height_i > HMax) h_d = HMax;
    else h_d = height_i;
    w_sum = {1'b0, w_d} + (DIM_W + 1)'(7);
    h_sum = {1'b0, h_d} + (DIM_W + 1)'(7);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q    <= item_i;
      w_q       <= w_d;
      h_q       <= h_d;
      stride_q  <= w_sum[DIM_W:3];
      vstride_q <= h_sum[DIM_W:3];
      mode_q    <= mode_i;
    end
  end

  assign row11 = {1'b0, item_q.row_index};

  always_comb begin
    case (item_q.kind)
      KIND_WRITE_BYTE: hit = (row11 < h_q) && ({2'b0, item_q.byte_column} < stride_q);
      KIND_SET_PIXEL:  hit = ({1'b0, item_q.pixel_x} < w_q) && ({1'b0, item_q.pixel_y} < h_q);
      KIND_READ: begin
        if (mode_q == MODE_ROTATE)
          hit = (row11 < w_q) && ({2'b0, item_q.byte_column} < vstride_q);
        else
          hit = (row11 < h_q) && ({2'b0, item_q.byte_column} < stride_q);
      end
      default: hit = 1'b0;
    endcase
  end

  assign sts_o.hit     = hit;
  assign sts_o.is_read = (item_q.kind == KIND_READ);

  // Source pixel for this step; padding bits in the flips stay in place
  always_comb begin
    xk = {1'b0, item_q.byte_column, cmd_i.step};
    sx = xk;
    sy = row11;
    en = 1'b1;
    case (item_q.kind)
      KIND_WRITE_BYTE: begin
        sx = {1'b0, item_q.byte_column, 3'b000};
      end
      KIND_SET_PIXEL: begin
        sx = {1'b0, item_q.pixel_x};
        sy = {1'b0, item_q.pixel_y};
      end
      default: begin
        if (mode_q == MODE_ROTATE) begin
          sx = w_q - DIM_W'(1) - row11;
          sy = xk;
          en = (xk < h_q);
        end else if (xk < w_q && mode_q == MODE_FLIP_H) begin
          sx = w_q - DIM_W'(1) - xk;
        end else if (xk < w_q && mode_q == MODE_FLIP_V) begin
          sy = h_q - DIM_W'(1) - row11;
        end
      end
    endcase
    prod      = ProdW'(sy) * ProdW'(stride_q);
    addr_calc = CalcW'(prod) + CalcW'(sx[DIM_W-1:3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= addr_calc[AW-1:0];
    sel1_q  <= sx[STEP_W-1:0];
    en1_q   <= en;
    k1_q    <= cmd_i.step;
    addr2_q <= addr1_q;
    sel2_q  <= sel1_q;
    en2_q   <= en1_q;
    k2_q    <= k1_q;
  end

  // Write back after the read returns (read-modify-write for a pixel set)
  always_comb begin
    pix_mask = 8'h80 >> sel2_q;
    wr_en    = v2_q && (item_q.kind == KIND_WRITE_BYTE || item_q.kind == KIND_SET_PIXEL);
    if (item_q.kind == KIND_WRITE_BYTE) wr_data = item_q.byte_data;
    else if (item_q.pixel_value) wr_data = rd_q | pix_mask;
    else wr_data = rd_q & ~pix_mask;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[addr2_q] <= wr_data;
    rd_q <= store_mem[addr1_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) result_q <= '0;
    else if (v2_q && item_q.kind == KIND_READ) result_q[~k2_q] <= en2_q & rd_q[~sel2_q];
    if (cmd_i.out_load) begin
      out_byte_q <= result_q;
      out_hit_q  <= hit;
    end
  end

  assign out_byte_o = out_byte_q;
  assign out_hit_o  = out_hit_q;

endmodule

// File: design/mono_bitmap_flip_rotate_core.sv
// A read inside the view makes one read of the image store per pixel of the returned byte,
// as the store has a single read port; an in-range byte write or pixel set makes one store
// access and any other item makes none. The next item is taken only once the result of the
// previous one has been loaded into the output register, so a result still waiting in the
// output register holds off the next item.
// Reset clears control state and sets width 600, height 800, mode as stored; the image
// store is not cleared and holds undefined data until written.
module mono_bitmap_flip_rotate_core
  import mbfr_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [9:0] row_index, [16:10] byte_column, [24:17] byte_data, [34:25] pixel_x,
  // [44:35] pixel_y, [45] pixel_value, [47:46] zero
  input  logic [47:0]       s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]        s_axis_tuser,
  // Output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [7:0] read_byte
  output logic [7:0]        m_axis_tdata,
  // [0] in_range
  output logic [0:0]        m_axis_tuser
);

  logic [DIM_W-1:0]  width_q, height_q;
  logic [MODE_W-1:0] mode_q;
  logic              cfg_wr;
  item_t             item;
  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic              out_hit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      mode_q   <= RST_MODE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        REG_MODE:   mode_q   <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      REG_MODE:   prdata = APB_DW'(mode_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    item.kind        = s_axis_tuser;
    item.row_index   = s_axis_tdata[9:0];
    item.byte_column = s_axis_tdata[16:10];
    item.byte_data   = s_axis_tdata[24:17];
    item.pixel_x     = s_axis_tdata[34:25];
    item.pixel_y     = s_axis_tdata[44:35];
    item.pixel_value = s_axis_tdata[45];
  end

  mbfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbfr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .item_i     (item),
    .width_i    (width_q),
    .height_i   (height_q),
    .mode_i     (mode_q),
    .out_byte_o (m_axis_tdata),
    .out_hit_o  (out_hit)
  );

  assign m_axis_tuser = out_hit;

  // One item at a time: no acceptance in the cycle after one
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while previous one still in work");

  // An out-of-range result carries a zero byte; so does any non-read result, though only the first is asserted
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("nonzero byte on out-of-range result");

  // The output register is only reloaded once its transaction is gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending result overwritten");

  // Store steps never overlap an item capture
  a_issue_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !cmd.load && !s_axis_tready)
    else $error("store step issued while taking an item");

endmodule

// File: dv/mono_bitmap_flip_rotate_core_tb.sv
// Self-checking testbench for mono_bitmap_flip_rotate_core: stream driver and monitor,
// APB configuration across several image sizes and readout views, and a bit-accurate
// predictor of the bitmap store. Depends on mbfr_pkg and the core itself.
`timescale 1ns / 1ps

module mono_bitmap_flip_rotate_core_tb;
  import mbfr_pkg::*;

  localparam int unsigned STORE_BYTES = ((DEF_MAX_WIDTH + 7) / 8) * DEF_MAX_HEIGHT;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RX_HOLD_CYCLES = 600;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_PHASES = 14;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              in_range;
  } view_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [47:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;
  logic [0:0]        m_axis_tuser;

  mono_bitmap_flip_rotate_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predictor state: own copy of the store and the registers
  logic [BYTE_W-1:0] img_mem [0:STORE_BYTES-1];
  bit                written [0:STORE_BYTES-1];
  logic [DIM_W-1:0]  cfg_w;
  logic [DIM_W-1:0]  cfg_h;
  logic [MODE_W-1:0] cfg_mode;
  int unsigned       touched_addr[$];

  item_t        pending_items[$];
  view_result_t predicted_bytes[$];

  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned rx_hold_arm;
  int unsigned rx_hold_seen;
  int unsigned rx_hold_left;
  int unsigned queued_cnt;
  int unsigned accepted_cnt;
  int unsigned results_seen;
  int unsigned reads_seen;
  int unsigned hits_seen;
  int unsigned mismatches;
  int unsigned cycle_cnt;

  int unsigned ph_w    [NUM_PHASES] = '{13, 13, 13, 13, 0, 1, 37, 20, 2047, 1024, 5, 100, 8, 1029};
  int unsigned ph_h    [NUM_PHASES] = '{9, 9, 9, 9, 0, 1, 20, 37, 2047, 1024, 70, 3, 8, 6};
  int unsigned ph_mode [NUM_PHASES] = '{0, 1, 2, 3, 3, 1, 2, 3, 3, 1, 3, 1, 0, 2};
  int unsigned ph_items[NUM_PHASES] = '{110, 110, 110, 110, 40, 40, 120, 120, 80, 80, 120, 120,
                                        150, 150};

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic src_pixel(int unsigned x, int unsigned y, int unsigned stride);
    int unsigned a;
    a = y * stride + (x >> 3);
    touched_addr.push_back(a);
    if (a >= STORE_BYTES) return 1'b0;
    return img_mem[a][7 - (x & 7)];
  endfunction

  // One byte of the image as seen through the current view; records every store
  // address it looks at so the generator can make sure each was written first.
  function automatic logic [BYTE_W-1:0] view_byte(int unsigned row, int unsigned col,
                                                  output logic hit);
    int unsigned w, h, stride, x, k;
    logic [BYTE_W-1:0] v;
    touched_addr.delete();
    w = clamp_dim(cfg_w, DEF_MAX_WIDTH);
    h = clamp_dim(cfg_h, DEF_MAX_HEIGHT);
    stride = (w + 7) / 8;
    v = '0;
    hit = 1'b0;
    if (cfg_mode == MODE_ROTATE) begin
      if (row < w && col < (h + 7) / 8) begin
        hit = 1'b1;
        for (k = 0; k < 8; k++) begin
          // padding beyond the source height reads as zero
          if (col * 8 + k < h) v[7 - k] = src_pixel(w - 1 - row, col * 8 + k, stride);
        end
      end
    end else if (row < h && col < stride) begin
      hit = 1'b1;
      for (k = 0; k < 8; k++) begin
        x = col * 8 + k;
        if (x >= w || cfg_mode == MODE_AS_STORED) v[7 - k] = src_pixel(x, row, stride);
        else if (cfg_mode == MODE_FLIP_H) v[7 - k] = src_pixel(w - 1 - x, row, stride);
        else v[7 - k] = src_pixel(x, h - 1 - row, stride);
      end
    end
    return v;
  endfunction

  function automatic view_result_t step_bitmap(item_t it);
    view_result_t r;
    int unsigned w, h, stride, a;
    w = clamp_dim(cfg_w, DEF_MAX_WIDTH);
    h = clamp_dim(cfg_h, DEF_MAX_HEIGHT);
    stride = (w + 7) / 8;
    r = '0;
    case (it.kind)
      KIND_WRITE_BYTE: begin
        if (it.row_index < h && it.byte_column < stride) begin
          img_mem[it.row_index * stride + it.byte_column] = it.byte_data;
          r.in_range = 1'b1;
        end
      end
      KIND_SET_PIXEL: begin
        if (it.pixel_x < w && it.pixel_y < h) begin
          a = it.pixel_y * stride + (it.pixel_x >> 3);
          img_mem[a][7 - (it.pixel_x & 7)] = it.pixel_value;
          r.in_range = 1'b1;
        end
      end
      KIND_READ: r.read_byte = view_byte(it.row_index, it.byte_column, r.in_range);
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t mk_item(logic [KIND_W-1:0] kind, int unsigned row, int unsigned col,
                                    int unsigned data, int unsigned px, int unsigned py,
                                    int unsigned pv);
    item_t it;
    it.kind        = kind;
    it.row_index   = row[ROW_W-1:0];
    it.byte_column = col[COL_W-1:0];
    it.byte_data   = data[BYTE_W-1:0];
    it.pixel_x     = px[PIX_W-1:0];
    it.pixel_y     = py[PIX_W-1:0];
    it.pixel_value = pv[0];
    return it;
  endfunction

  // Queues an item; a read is preceded by byte writes to any store entry it
  // would touch that has never been written.
  task automatic queue_item(item_t it);
    item_t fill;
    logic rd_hit;
    logic [63:0] rnd;
    int unsigned h, stride;
    h = clamp_dim(cfg_h, DEF_MAX_HEIGHT);
    stride = (clamp_dim(cfg_w, DEF_MAX_WIDTH) + 7) / 8;
    if (it.kind == KIND_READ) begin
      void'(view_byte(it.row_index, it.byte_column, rd_hit));
      foreach (touched_addr[i]) begin
        if (!written[touched_addr[i]]) begin
          rnd = {$urandom, $urandom};
          fill = rnd[47:0];
          fill.kind = KIND_WRITE_BYTE;
          fill.row_index = ROW_W'(touched_addr[i] / stride);
          fill.byte_column = COL_W'(touched_addr[i] % stride);
          written[touched_addr[i]] = 1'b1;
          pending_items.push_back(fill);
          queued_cnt++;
        end
      end
    end else if (it.kind == KIND_WRITE_BYTE && it.row_index < h && it.byte_column < stride) begin
      written[it.row_index * stride + it.byte_column] = 1'b1;
    end
    pending_items.push_back(it);
    queued_cnt++;
  endtask

  task automatic fill_phase(int unsigned budget);
    item_t it;
    logic [63:0] rnd;
    int unsigned w, h, stride, vh, vstride, roll, start;
    w = clamp_dim(cfg_w, DEF_MAX_WIDTH);
    h = clamp_dim(cfg_h, DEF_MAX_HEIGHT);
    stride = (w + 7) / 8;
    if (cfg_mode == MODE_ROTATE) begin
      vh = w;
      vstride = (h + 7) / 8;
    end else begin
      vh = h;
      vstride = stride;
    end
    start = queued_cnt;
    while (queued_cnt - start < budget) begin
      rnd = {$urandom, $urandom};
      it = rnd[47:0];
      roll = $urandom_range(99);
      if (roll < 35) begin
        it.kind = KIND_READ;
        if ($urandom_range(99) < 85) begin
          it.row_index = ROW_W'($urandom_range(vh - 1));
          it.byte_column = COL_W'($urandom_range(vstride - 1));
        end
      end else if (roll < 65) begin
        it.kind = KIND_WRITE_BYTE;
        if ($urandom_range(99) < 85) begin
          it.row_index = ROW_W'($urandom_range(h - 1));
          it.byte_column = COL_W'($urandom_range(stride - 1));
        end
      end else if (roll < 90) begin
        it.kind = KIND_SET_PIXEL;
        if ($urandom_range(99) < 85) begin
          it.pixel_x = PIX_W'($urandom_range(w - 1));
          it.pixel_y = PIX_W'($urandom_range(h - 1));
        end
      end
      // otherwise noise: any kind, unknown included, with raw coordinates
      queue_item(it);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_w = val[DIM_W-1:0];
      REG_HEIGHT: cfg_h = val[DIM_W-1:0];
      REG_MODE:   cfg_mode = val[MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (pending_items.size() != 0 || predicted_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               predicted_bytes.size());
      $display("mono_bitmap_flip_rotate_core_tb failed");
      $finish;
    end
  end

  // Stream driver
  always @(posedge clk_i) begin : drv
    logic took;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        predicted_bytes.push_back(step_bitmap(pending_items.pop_front()));
        accepted_cnt++;
      end
      if (!s_axis_tvalid || took) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, pending_items[0].pixel_value, pending_items[0].pixel_y,
                            pending_items[0].pixel_x, pending_items[0].byte_data,
                            pending_items[0].byte_column, pending_items[0].row_index};
          s_axis_tuser  <= pending_items[0].kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once from the sequence
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_arm != rx_hold_seen) begin
      rx_hold_left <= RX_HOLD_CYCLES;
      rx_hold_seen <= rx_hold_arm;
    end
  end

  // Result monitor and checker
  always @(posedge clk_i) begin : mon
    view_result_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (predicted_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: byte %h in_range %b", $realtime,
                     m_axis_tdata, m_axis_tuser[0]);
        end else begin
          exp = predicted_bytes.pop_front();
          if (exp.in_range) hits_seen++;
          if (m_axis_tdata !== exp.read_byte || m_axis_tuser[0] !== exp.in_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result %0d: byte exp %h got %h, in_range exp %b got %b",
                       $realtime, results_seen, exp.read_byte, m_axis_tdata, exp.in_range,
                       m_axis_tuser[0]);
          end
        end
      end
      m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    rx_hold_arm = 0;
    rx_hold_seen = 0;
    rx_hold_left = 0;
    queued_cnt = 0;
    accepted_cnt = 0;
    results_seen = 0;
    reads_seen = 0;
    hits_seen = 0;
    mismatches = 0;
    cycle_cnt = 0;
    cfg_w = RST_WIDTH;
    cfg_h = RST_HEIGHT;
    cfg_mode = RST_MODE;
    for (int i = 0; i < STORE_BYTES; i++) img_mem[i] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset geometry 600x800, stride 75, view as stored
    queue_item(mk_item(KIND_WRITE_BYTE, 0, 0, 8'hA5, 0, 0, 0));
    queue_item(mk_item(KIND_WRITE_BYTE, 799, 74, 8'h5A, 1023, 1023, 1));
    queue_item(mk_item(KIND_WRITE_BYTE, 800, 0, 8'hFF, 0, 0, 0));
    queue_item(mk_item(KIND_WRITE_BYTE, 0, 75, 8'hFF, 0, 0, 0));
    queue_item(mk_item(KIND_WRITE_BYTE, 1023, 127, 8'hFF, 1023, 1023, 1));
    queue_item(mk_item(KIND_SET_PIXEL, 0, 0, 0, 0, 0, 1));
    queue_item(mk_item(KIND_SET_PIXEL, 1023, 127, 8'hFF, 599, 799, 0));
    queue_item(mk_item(KIND_SET_PIXEL, 0, 0, 0, 600, 0, 1));
    queue_item(mk_item(KIND_SET_PIXEL, 0, 0, 0, 0, 800, 1));
    queue_item(mk_item(KIND_SET_PIXEL, 0, 0, 0, 1023, 1023, 1));
    queue_item(mk_item(KIND_READ, 0, 0, 0, 0, 0, 0));
    queue_item(mk_item(KIND_READ, 799, 74, 8'hFF, 1023, 1023, 1));
    queue_item(mk_item(KIND_READ, 800, 0, 0, 0, 0, 0));
    queue_item(mk_item(KIND_READ, 0, 75, 0, 0, 0, 0));
    queue_item(mk_item(KIND_READ, 1023, 127, 0, 0, 0, 0));
    queue_item(mk_item(KIND_UNUSED, 1023, 127, 8'hFF, 1023, 1023, 1));
    queue_item(mk_item(KIND_WRITE_BYTE, 1, 1, 8'h00, 1023, 0, 1));
    queue_item(mk_item(KIND_SET_PIXEL, 0, 0, 0, 13, 1, 1));
    queue_item(mk_item(KIND_READ, 1, 1, 0, 0, 0, 0));
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_write(REG_WIDTH, ph_w[p]);
      cfg_write(REG_HEIGHT, ph_h[p]);
      cfg_write(REG_MODE, ph_mode[p]);
      @(negedge clk_i);
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 80; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 80; end
        default: begin send_gap_pct = 34; recv_stall_pct = 34; end
      endcase
      // back-pressure the output long enough for the core to stall its input
      if (p == 0) rx_hold_arm++;
      fill_phase(ph_items[p]);
      wait_idle();
    end

    if (predicted_bytes.size() != 0) mismatches++;
    $display("covered %0d transactions (%0d reads) over %0d configurations and all four views",
             accepted_cnt, reads_seen, NUM_PHASES + 1);
    $display("%0d results checked, %0d in range, %0d mismatches",
             results_seen, hits_seen, mismatches);
    if (mismatches == 0) begin
      $display("mono_bitmap_flip_rotate_core_tb passed");
    end else begin
      $display("mono_bitmap_flip_rotate_core_tb failed");
    end
    $finish;
  end

  // Count reads as they reach the core, for the summary
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_READ) reads_seen++;
  end

endmodule

// File: mono_bitmap_flip_rotate_core.f
design/mbfr_pkg.sv
design/mbfr_ctrl.sv
design/mbfr_datapath.sv
design/mono_bitmap_flip_rotate_core.sv
dv/mono_bitmap_flip_rotate_core_tb.sv
